// ===== hw/rtl/dfalex_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults of the table-driven DFA lexer.
// No dependencies; every other file of the block imports this package.
package dfalex_pkg;

    localparam int NUM_STATES_DEF    = 256;
    localparam int NUM_TERMINALS_DEF = 64;
    localparam int POSITION_BITS_DEF = 16;

    // Result queue depth and the widths that follow from it.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_LOAD_TRANS  = 3'd0,
        OP_LOAD_ACCEPT = 3'd1,
        OP_LOAD_SKIP   = 3'd2,
        OP_CHAR        = 3'd3,
        OP_END         = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_TOKEN = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] table_state;
        logic [7:0] table_char;
        logic [7:0] next_state_value;
        logic [5:0] terminal_value;
        logic       skip_value;
        logic [7:0] source_char;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  token_terminal;
        logic [15:0] token_from;
        logic [15:0] token_to;
        logic [15:0] error_position;
        logic        last;
    } t_res_item;

    // Up to two result items written into the queue in one cycle, a before b.
    typedef struct packed {
        logic [1:0] n;
        t_res_item  a;
        t_res_item  b;
    } t_push;

    // Table write request, already range checked.
    typedef struct packed {
        logic       trans_we;
        logic       acc_we;
        logic       skip_we;
        logic [7:0] state;
        logic [7:0] chr;
        logic [7:0] nxt;
        logic [5:0] term;
        logic       skip;
    } t_tbl_wr;

    function automatic t_res_item mk_token(input logic [5:0] term, input logic [15:0] from,
                                           input logic [15:0] upto, input logic last);
        t_res_item r;
        r                = '0;
        r.kind           = KIND_TOKEN;
        r.token_terminal = term;
        r.token_from     = from;
        r.token_to       = upto;
        r.last           = last;
        return r;
    endfunction

    function automatic t_res_item mk_error(input logic [15:0] pos);
        t_res_item r;
        r                = '0;
        r.kind           = KIND_ERROR;
        r.error_position = pos;
        r.last           = 1'b1;
        return r;
    endfunction

    function automatic t_res_item mk_done();
        t_res_item r;
        r      = '0;
        r.kind = KIND_DONE;
        r.last = 1'b1;
        return r;
    endfunction

endpackage

// ===== hw/rtl/dfalex_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
// Depends on dfalex_pkg for the payload structs.
interface dfalex_in_if import dfalex_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dfalex_res_if import dfalex_pkg::*; ();
    logic      valid;
    logic      ready;
    t_res_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/dfalex_tables.sv =====
`timescale 1ns / 1ps
// Transition, accept and skip memories of the lexer, one write and one
// registered read per memory per cycle. Depends on dfalex_pkg.
module dfalex_tables import dfalex_pkg::*; #(
    parameter int NUM_STATES    = NUM_STATES_DEF,
    parameter int NUM_TERMINALS = NUM_TERMINALS_DEF,
    localparam int SB = $clog2(NUM_STATES),
    localparam int TB = $clog2(NUM_TERMINALS)
) (
    input  logic          i_clk,
    input  t_tbl_wr       i_wr,
    input  logic [SB+7:0] i_trans_raddr,
    input  logic [SB-1:0] i_acc_raddr,
    input  logic [TB-1:0] i_skip_raddr,
    output logic [SB-1:0] o_trans_rdata,
    output logic [5:0]    o_acc_rdata,
    output logic          o_skip_rdata
);

    localparam int TRANS_DEPTH = NUM_STATES * 256;

    logic [SB-1:0] r_trans_mem [0:TRANS_DEPTH-1];
    logic [5:0]    r_acc_mem   [0:NUM_STATES-1];
    logic          r_skip_mem  [0:NUM_TERMINALS-1];

    logic [SB+7:0] trans_waddr;

    assign trans_waddr = {SB'(i_wr.state), i_wr.chr};

    always_ff @(posedge i_clk) begin
        if (i_wr.trans_we) begin
            r_trans_mem[trans_waddr] <= SB'(i_wr.nxt);
        end
        o_trans_rdata <= r_trans_mem[i_trans_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.acc_we) begin
            r_acc_mem[SB'(i_wr.state)] <= i_wr.term;
        end
        o_acc_rdata <= r_acc_mem[i_acc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.skip_we) begin
            r_skip_mem[TB'(i_wr.term)] <= i_wr.skip;
        end
        o_skip_rdata <= r_skip_mem[i_skip_raddr];
    end

endmodule

// ===== hw/rtl/dfalex_outq.sv =====
`timescale 1ns / 1ps
// Small result queue that takes up to two items per cycle and drives the
// result channel. Depends on dfalex_pkg and dfalex_res_if.
module dfalex_outq import dfalex_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_push              i_push,
    output logic [OUTQ_CW-1:0] o_count,
    dfalex_res_if.source       o_res
);

    t_res_item          r_mem [0:OUTQ_DEPTH-1];
    logic [OUTQ_AW-1:0] r_wp;
    logic [OUTQ_AW-1:0] r_rp;
    logic [OUTQ_CW-1:0] r_count;
    logic [OUTQ_AW-1:0] wp_next;
    logic               pop;

    assign pop           = o_res.valid && o_res.ready;
    assign wp_next       = r_wp + 1'b1;
    assign o_res.valid   = (r_count != '0);
    assign o_res.payload = r_mem[r_rp];
    assign o_count       = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + OUTQ_AW'(i_push.n);
            r_rp    <= r_rp + OUTQ_AW'(pop);
            r_count <= r_count + OUTQ_CW'(i_push.n) - OUTQ_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wp] <= i_push.a;
        end
        if (i_push.n == 2'd2) begin
            r_mem[wp_next] <= i_push.b;
        end
    end

endmodule

// ===== hw/rtl/dfa_lexer_token_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the table-driven DFA lexer: scan sequencer, tables and queue.
// Depends on dfalex_pkg, dfalex_ifs, dfalex_tables and dfalex_outq.
//
// Load items write one table entry each. For a character item the transition
// memory is read with the current state and the character, then the accept
// memory is read with the successor state; the next item is taken while that
// second read completes. A dead transition with a pending token goes through
// the restart state for the skip lookup and the restart read from the start
// state; a dead transition with nothing pending ends in an error, and then
// characters are dropped until end of input. End of input passes through the
// EOI and FLUSH states, or only EOI while the scanner is halted. The tables
// need no clearing after reset. Results go through a four-entry queue, and
// input items are held off while more than two results wait in it.
module dfa_lexer_token_scanner import dfalex_pkg::*; #(
    parameter int NUM_STATES    = NUM_STATES_DEF,
    parameter int NUM_TERMINALS = NUM_TERMINALS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dfalex_in_if.sink    i_in,
    dfalex_res_if.source o_res
);

    localparam int SB = $clog2(NUM_STATES);
    localparam int TB = $clog2(NUM_TERMINALS);
    localparam int PB = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [OUTQ_CW-1:0] Q_LIMIT = OUTQ_CW'(OUTQ_DEPTH - 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_ACC,
        S_RESTART,
        S_EOI,
        S_FLUSH
    } t_fsm;

    t_fsm          r_fsm;
    logic [SB-1:0] r_state;
    logic [5:0]    r_pend;
    logic [PB-1:0] r_pend_end;
    logic [PB-1:0] r_tok_start;
    logic [PB-1:0] r_pos;
    logic [PB-1:0] r_mark;
    logic          r_halted;
    logic [7:0]    r_chr;
    logic [5:0]    r_emit_term;
    logic [PB-1:0] r_emit_from;
    logic [PB-1:0] r_emit_to;

    t_in_item           in_item;
    logic               acc_in;
    logic               can_take;
    t_tbl_wr            tbl_wr;
    logic [SB+7:0]      trans_raddr;
    logic [SB-1:0]      trans_rdata;
    logic [5:0]         acc_rdata;
    logic               skip_rdata;
    logic               live;
    logic [PB-1:0]      pos_inc;
    logic [PB-1:0]      end_inc;
    t_push              push;
    logic [OUTQ_CW-1:0] q_count;

    assign in_item    = i_in.payload;
    assign can_take   = ((r_fsm == S_IDLE) || (r_fsm == S_ACC)) && (q_count <= Q_LIMIT);
    assign i_in.ready = can_take;
    assign acc_in     = i_in.valid && can_take;
    assign live       = (trans_rdata != '0);
    assign pos_inc    = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign end_inc    = (r_pend_end == POS_MAX) ? r_pend_end : r_pend_end + 1'b1;

    // Loads that address a state or terminal beyond the tables are dropped.
    always_comb begin
        tbl_wr          = '0;
        tbl_wr.state    = in_item.table_state;
        tbl_wr.chr      = in_item.table_char;
        tbl_wr.nxt      = in_item.next_state_value;
        tbl_wr.term     = in_item.terminal_value;
        tbl_wr.skip     = in_item.skip_value;
        tbl_wr.trans_we = acc_in && (in_item.op == OP_LOAD_TRANS)
                          && (32'(in_item.table_state) < 32'(NUM_STATES))
                          && (32'(in_item.next_state_value) < 32'(NUM_STATES));
        tbl_wr.acc_we   = acc_in && (in_item.op == OP_LOAD_ACCEPT)
                          && (32'(in_item.table_state) < 32'(NUM_STATES))
                          && (32'(in_item.terminal_value) < 32'(NUM_TERMINALS));
        tbl_wr.skip_we  = acc_in && (in_item.op == OP_LOAD_SKIP)
                          && (32'(in_item.terminal_value) < 32'(NUM_TERMINALS));
    end

    // The restart after a dead step looks up the same character from state 1.
    assign trans_raddr = (r_fsm == S_STEP) ? {SB'(1), r_chr}
                                           : {r_state, in_item.source_char};

    dfalex_tables #(
        .NUM_STATES   (NUM_STATES),
        .NUM_TERMINALS(NUM_TERMINALS)
    ) u_tables (
        .i_clk        (i_clk),
        .i_wr         (tbl_wr),
        .i_trans_raddr(trans_raddr),
        .i_acc_raddr  (trans_rdata),
        .i_skip_raddr (TB'(r_pend)),
        .o_trans_rdata(trans_rdata),
        .o_acc_rdata  (acc_rdata),
        .o_skip_rdata (skip_rdata)
    );

    always_comb begin
        push = '0;
        unique case (r_fsm)
            S_STEP: begin
                if (!live && (r_pend == '0)) begin
                    push.n = 2'd1;
                    push.a = mk_error(16'(r_pos));
                end
            end
            S_RESTART: begin
                if (!skip_rdata) begin
                    push.a = mk_token(r_emit_term, 16'(r_emit_from), 16'(r_emit_to), live);
                    push.b = mk_error(16'(r_pos));
                    push.n = live ? 2'd1 : 2'd2;
                end else if (!live) begin
                    push.a = mk_error(16'(r_pos));
                    push.n = 2'd1;
                end
            end
            S_FLUSH: begin
                if ((r_pend != '0) && !skip_rdata) begin
                    push.a = mk_token(r_pend, 16'(r_tok_start), 16'(end_inc), 1'b0);
                    push.b = mk_done();
                    push.n = 2'd2;
                end else begin
                    push.a = mk_done();
                    push.n = 2'd1;
                end
            end
            default: begin
                push.n = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_state     <= SB'(1);
            r_pend      <= '0;
            r_pend_end  <= '0;
            r_tok_start <= '0;
            r_pos       <= '0;
            r_mark      <= '0;
            r_halted    <= 1'b0;
            r_chr       <= '0;
            r_emit_term <= '0;
            r_emit_from <= '0;
            r_emit_to   <= '0;
        end else begin
            unique case (r_fsm)
                S_IDLE, S_ACC: begin
                    // Finish the accept lookup of the previous character.
                    if ((r_fsm == S_ACC) && (acc_rdata != '0)) begin
                        r_pend     <= acc_rdata;
                        r_pend_end <= r_mark;
                    end
                    if (acc_in) begin
                        unique case (in_item.op)
                            OP_CHAR: begin
                                r_chr <= in_item.source_char;
                                r_fsm <= r_halted ? S_IDLE : S_STEP;
                            end
                            OP_END: begin
                                r_fsm <= S_EOI;
                            end
                            default: begin
                                r_fsm <= S_IDLE;
                            end
                        endcase
                    end else begin
                        r_fsm <= S_IDLE;
                    end
                end
                S_STEP: begin
                    if (live) begin
                        r_state <= trans_rdata;
                        r_pos   <= pos_inc;
                        r_mark  <= r_pos;
                        r_fsm   <= S_ACC;
                    end else if (r_pend != '0) begin
                        r_emit_term <= r_pend;
                        r_emit_from <= r_tok_start;
                        r_emit_to   <= end_inc;
                        r_pend      <= '0;
                        r_tok_start <= r_pos;
                        r_state     <= SB'(1);
                        r_fsm       <= S_RESTART;
                    end else begin
                        r_halted <= 1'b1;
                        r_fsm    <= S_IDLE;
                    end
                end
                S_RESTART: begin
                    if (live) begin
                        r_state <= trans_rdata;
                        r_pos   <= pos_inc;
                        r_mark  <= r_pos;
                        r_fsm   <= S_ACC;
                    end else begin
                        r_halted <= 1'b1;
                        r_fsm    <= S_IDLE;
                    end
                end
                S_EOI, S_FLUSH: begin
                    // A halted stream ends silently; otherwise go on to S_FLUSH, where the
                    // skip flag of the pending token has been read.
                    if ((r_fsm == S_EOI) && !r_halted) begin
                        r_fsm <= S_FLUSH;
                    end else begin
                        r_pos       <= '0;
                        r_pend_end  <= '0;
                        r_halted    <= 1'b0;
                        r_state     <= SB'(1);
                        r_pend      <= '0;
                        r_tok_start <= '0;
                        r_fsm       <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    dfalex_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_count(q_count),
        .o_res  (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.n != 2'd0) |-> (32'(q_count) + 32'(push.n) <= 32'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((push.n != 2'd0) && (push.a.kind == KIND_ERROR))
         || ((push.n == 2'd2) && (push.b.kind == KIND_ERROR)))
        |=> r_halted)
        else $error("error result without halting the scanner");

    a_state_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != '0)
        else $error("scanner entered the dead state");

    a_acc_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_ACC) |-> (($past(r_fsm) == S_STEP) || ($past(r_fsm) == S_RESTART)))
        else $error("accept lookup without a live step");

    a_halted_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> ((r_fsm != S_STEP) && (r_fsm != S_RESTART)))
        else $error("character processed while halted");

endmodule
